// File: design/keyed_timer_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keyed timer table
// Shared property forms used by the RTL of the timer table.
// ---------------------------------------------------------------------------
`ifndef KEYED_TIMER_TABLE_ASSERT_SVH
`define KEYED_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define KTT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed_timer_table: same-cycle property failed");

// Next-cycle implication, off during reset.
`define KTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed_timer_table: next-cycle property failed");

`endif

// File: design/ktt_pkg.sv
// ---------------------------------------------------------------------------
// Keyed timer table package
// Sizes, action and status codes and the token that walks the cell row.
// ---------------------------------------------------------------------------
`default_nettype none

package ktt_pkg;

   localparam int NUM_TIMERS   = 16;
   localparam int KEY_BITS     = 16;
   localparam int COUNT_BITS   = 31;
   localparam int LIMIT_BITS   = 31;
   localparam int ELAPSED_BITS = 16;
   localparam int ACTION_BITS  = 3;
   localparam int STATUS_BITS  = 2;

   // compare width for count against limit, sum width for saturating add
   localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam int SUM_BITS = ((COUNT_BITS > ELAPSED_BITS) ? COUNT_BITS : ELAPSED_BITS) + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_REGISTER   = 3'd0,
      ACT_UNREGISTER = 3'd1,
      ACT_TICK       = 3'd2,
      ACT_CHECK      = 3'd3,
      ACT_RESET_CNT  = 3'd4,
      ACT_SET_LIMIT  = 3'd5
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_DONE      = 2'd0,
      STAT_EXISTS    = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // One command word in flight through the cell row.
   typedef struct packed {
      logic                    vld;
      logic                    insert;     // second pass of a register
      logic                    pending;    // insert not yet claimed by a cell
      logic                    found;      // key matched in some cell
      logic                    free_seen;  // some cell was empty
      logic                    expired;
      action_type              action;
      logic [KEY_BITS-1:0]     key;
      logic [LIMIT_BITS-1:0]   limit;
      logic [ELAPSED_BITS-1:0] elapsed;
   } tok_type;

endpackage

`default_nettype wire

// File: design/keyed_timer_table.sv
// ---------------------------------------------------------------------------
// Keyed timer table
// Table of keyed elapsed-time timers built as a row of per-timer cells.
// ---------------------------------------------------------------------------
// Each request word is one action (register, unregister, tick, check, reset
// count, set limit) and returns exactly one response word with a status and,
// for check, the expired flag. The word walks down a row of NUM_TIMERS cells,
// one cell per cycle, each cell holding one timer. A register that succeeds
// walks the row a second time to fill the lowest free cell. One action is
// in the row at a time. A finished response sits in an output register, so
// the next request is taken while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module keyed_timer_table (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [ktt_pkg::ACTION_BITS-1:0]    req_action,
   input  wire logic [15:0]                        req_timer_key,
   input  wire logic [ktt_pkg::LIMIT_BITS-1:0]     req_limit_value,
   input  wire logic [ktt_pkg::ELAPSED_BITS-1:0]   req_elapsed,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [ktt_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic                                    rsp_expired
);

`include "keyed_timer_table_assert.svh"

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_INSERT = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   ktt_pkg::tok_type                   launch_ff, launch_in;
   ktt_pkg::tok_type                   result_ff, result_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ktt_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic                               rsp_expired_ff, rsp_expired_in;

   // chain[i] feeds cell i; chain[NUM_TIMERS] is the tail of the row
   ktt_pkg::tok_type                   chain [ktt_pkg::NUM_TIMERS+1];
   ktt_pkg::tok_type                   tail;
   logic [ktt_pkg::NUM_TIMERS:0]       vld_vec;
   logic                               req_fire;
   logic                               rsp_load;

   assign chain[0] = launch_ff;
   assign tail     = chain[ktt_pkg::NUM_TIMERS];

   for (genvar i = 0; i < ktt_pkg::NUM_TIMERS; i++) begin : g_cell
      ktt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (chain[i]),
         .tok_o (chain[i+1])
      );
   end

   always_comb begin
      for (int i = 0; i <= ktt_pkg::NUM_TIMERS; i++) begin
         vld_vec[i] = chain[i].vld;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Fold the flags gathered along the row into a status code.
   function automatic ktt_pkg::status_type status_of(input ktt_pkg::tok_type t);
      ktt_pkg::status_type s;
      s = ktt_pkg::STAT_DONE;
      case (t.action)
         ktt_pkg::ACT_REGISTER: begin
            if (t.found) begin
               s = ktt_pkg::STAT_EXISTS;
            end else if (!t.free_seen) begin
               s = ktt_pkg::STAT_FULL;
            end
         end
         ktt_pkg::ACT_UNREGISTER, ktt_pkg::ACT_CHECK,
         ktt_pkg::ACT_RESET_CNT, ktt_pkg::ACT_SET_LIMIT: begin
            if (!t.found) begin
               s = ktt_pkg::STAT_NOT_FOUND;
            end
         end
         default: begin
            s = ktt_pkg::STAT_DONE;
         end
      endcase
      return s;
   endfunction

   always_comb begin
      state_in       = state_ff;
      launch_in      = launch_ff;
      launch_in.vld  = 1'b0;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_expired_in = rsp_expired_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // launch a search word at the head of the row
               launch_in.vld       = 1'b1;
               launch_in.insert    = 1'b0;
               launch_in.pending   = 1'b0;
               launch_in.found     = 1'b0;
               launch_in.free_seen = 1'b0;
               launch_in.expired   = 1'b0;
               launch_in.action    = ktt_pkg::action_type'(req_action);
               launch_in.key       = (ktt_pkg::KEY_BITS)'(req_timer_key);
               launch_in.limit     = req_limit_value;
               launch_in.elapsed   = req_elapsed;
               state_in            = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tail.vld) begin
               if (tail.action == ktt_pkg::ACT_REGISTER && !tail.found && tail.free_seen) begin
                  // no duplicate and room left: walk again to fill a cell
                  launch_in         = tail;
                  launch_in.insert  = 1'b1;
                  launch_in.pending = 1'b1;
                  state_in          = ST_INSERT;
               end else begin
                  result_in = tail;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_INSERT: begin
            if (tail.vld) begin
               result_in = tail;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_of(result_ff);
               rsp_expired_in = result_ff.expired;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff      <= result_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_expired_ff <= rsp_expired_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_expired = rsp_expired_ff;

   // Only one command word may be in the row at a time.
   `KTT_ASSERT_IMPLY(a_single_word, clock, reset, 1'b1, $countones(vld_vec) <= 1)
   // The row is empty whenever a new request can be taken.
   `KTT_ASSERT_IMPLY(a_idle_empty, clock, reset, state_ff == ST_IDLE, vld_vec == '0)
   // A word reaches the tail only while the controller waits for it.
   `KTT_ASSERT_IMPLY(a_tail_expected, clock, reset, tail.vld,
      state_ff == ST_SEARCH || state_ff == ST_INSERT)
   // A fill pass always finds its free cell.
   `KTT_ASSERT_IMPLY(a_insert_claimed, clock, reset, tail.vld && tail.insert,
      !tail.pending && tail.action == ktt_pkg::ACT_REGISTER)
   // A loaded response shows on the port in the next cycle.
   `KTT_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid && state_ff == ST_IDLE)

endmodule

`default_nettype wire

// File: design/ktt_cell.sv
// ---------------------------------------------------------------------------
// Keyed timer table cell
// Holds one timer entry and applies the passing command word to it.
// ---------------------------------------------------------------------------
`default_nettype none

module ktt_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ktt_pkg::tok_type tok_i,
   output ktt_pkg::tok_type      tok_o
);

   logic                             valid_ff, valid_in;
   logic [ktt_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [ktt_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic [ktt_pkg::LIMIT_BITS-1:0]   limit_ff, limit_in;
   ktt_pkg::tok_type                 tok_ff, tok_in;

   logic                             match;
   logic [ktt_pkg::SUM_BITS-1:0]     sum;
   logic [ktt_pkg::COUNT_BITS-1:0]   sat_count;
   logic                             reached;

   assign match = valid_ff && (key_ff == tok_i.key);
   assign sum   = ktt_pkg::SUM_BITS'(count_ff) + ktt_pkg::SUM_BITS'(tok_i.elapsed);
   assign sat_count = (sum > ktt_pkg::SUM_BITS'(ktt_pkg::COUNT_MAX)) ?
                      ktt_pkg::COUNT_MAX : sum[ktt_pkg::COUNT_BITS-1:0];
   assign reached = ktt_pkg::CMP_BITS'(count_ff) >= ktt_pkg::CMP_BITS'(limit_ff);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      limit_in = limit_ff;
      tok_in   = tok_i;
      if (tok_i.vld && tok_i.insert) begin
         // claim the insert at the first empty cell
         if (tok_i.pending && !valid_ff) begin
            valid_in       = 1'b1;
            key_in         = tok_i.key;
            count_in       = '0;
            limit_in       = tok_i.limit;
            tok_in.pending = 1'b0;
         end
      end else if (tok_i.vld) begin
         if (match) begin
            tok_in.found = 1'b1;
         end
         case (tok_i.action)
            ktt_pkg::ACT_REGISTER: begin
               if (!valid_ff) begin
                  tok_in.free_seen = 1'b1;
               end
            end
            ktt_pkg::ACT_UNREGISTER: begin
               if (match) begin
                  valid_in = 1'b0;
               end
            end
            ktt_pkg::ACT_TICK: begin
               if (valid_ff) begin
                  count_in = sat_count;
               end
            end
            ktt_pkg::ACT_CHECK: begin
               if (match) begin
                  tok_in.expired = reached;
               end
            end
            ktt_pkg::ACT_RESET_CNT: begin
               if (match) begin
                  count_in = '0;
               end
            end
            ktt_pkg::ACT_SET_LIMIT: begin
               if (match) begin
                  limit_in = tok_i.limit;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      count_ff <= count_in;
      limit_ff <= limit_in;
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Keyed timer table testbench
// Sends action words through the request channel, predicts each response
// from a private copy of the timer table or takes it fixed, and checks the responses in order.
// ---------------------------------------------------------------------------
module tb_top;
   import ktt_pkg::*;

   // action codes the block has no name for; they must answer done
   localparam logic [ACTION_BITS-1:0] ACT_SPARE6 = 3'd6;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE7 = 3'd7;

   localparam int RANDOM_WORDS = 2000;
   localparam int FULL_TICKS   = 4;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 2 * NUM_TIMERS + 8;
   localparam int REPORT_LIMIT = 10;
   localparam int KEY_POOL     = 24;
   localparam int FILL_BASE    = 16'h0100;

   localparam logic [LIMIT_BITS-1:0]   LIMIT_TOP   = '1;
   localparam logic [ELAPSED_BITS-1:0] ELAPSED_TOP = '1;

   typedef struct packed {
      status_type status;
      logic       expired;
   } timer_outcome_t;

   typedef struct packed {
      logic [ACTION_BITS-1:0]  action;
      logic [15:0]             key;
      logic [LIMIT_BITS-1:0]   limit;
      logic [ELAPSED_BITS-1:0] elapsed;
      logic                    typed;    // outcome below is fixed, not predicted
      timer_outcome_t          outcome;
   } stim_row_t;

   // Opening sequence. Rows with typed set carry an outcome known by
   // inspection; the rest take their outcome from the predictor.
   localparam stim_row_t DIRECTED_ROWS [22] = '{
      // empty table: every keyed action misses
      '{ACT_CHECK,      16'h0000, 31'd0,     16'd0,       1'b1, '{STAT_NOT_FOUND, 1'b0}},
      '{ACT_UNREGISTER, 16'hFFFF, 31'd0,     16'd0,       1'b1, '{STAT_NOT_FOUND, 1'b0}},
      '{ACT_RESET_CNT,  16'h1234, 31'd0,     16'd0,       1'b1, '{STAT_NOT_FOUND, 1'b0}},
      '{ACT_SET_LIMIT,  16'h1234, LIMIT_TOP, 16'd0,       1'b1, '{STAT_NOT_FOUND, 1'b0}},
      '{ACT_TICK,       16'h0000, 31'd0,     ELAPSED_TOP, 1'b1, '{STAT_DONE,      1'b0}},
      // undefined actions with every other field at its top
      '{ACT_SPARE6,     16'hFFFF, LIMIT_TOP, ELAPSED_TOP, 1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_SPARE7,     16'hFFFF, LIMIT_TOP, ELAPSED_TOP, 1'b1, '{STAT_DONE,      1'b0}},
      // zero limit is reached at once, a second register is a duplicate
      '{ACT_REGISTER,   16'h0000, 31'd0,     16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_CHECK,      16'h0000, 31'd0,     16'd0,       1'b1, '{STAT_DONE,      1'b1}},
      '{ACT_REGISTER,   16'h0000, 31'd5,     16'd0,       1'b1, '{STAT_EXISTS,    1'b0}},
      '{ACT_REGISTER,   16'hFFFF, LIMIT_TOP, 16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_TICK,       16'h0000, 31'd0,     ELAPSED_TOP, 1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_CHECK,      16'hFFFF, 31'd0,     16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      // count equal to limit expires, one below does not
      '{ACT_SET_LIMIT,  16'hFFFF, 31'hFFFF,  16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_CHECK,      16'hFFFF, 31'd0,     16'd0,       1'b1, '{STAT_DONE,      1'b1}},
      '{ACT_SET_LIMIT,  16'hFFFF, 31'h10000, 16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_CHECK,      16'hFFFF, 31'd0,     16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_RESET_CNT,  16'hFFFF, 31'd0,     16'd0,       1'b0, '{STAT_DONE,      1'b0}},
      '{ACT_CHECK,      16'h0000, 31'd0,     16'd0,       1'b0, '{STAT_DONE,      1'b0}},
      '{ACT_UNREGISTER, 16'h0000, 31'd0,     16'd0,       1'b1, '{STAT_DONE,      1'b0}},
      '{ACT_CHECK,      16'h0000, 31'd0,     16'd0,       1'b1, '{STAT_NOT_FOUND, 1'b0}},
      '{ACT_TICK,       16'hABCD, 31'd0,     16'h5555,    1'b0, '{STAT_DONE,      1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [ACTION_BITS-1:0]  req_action      = '0;
   logic [15:0]             req_timer_key   = '0;
   logic [LIMIT_BITS-1:0]   req_limit_value = '0;
   logic [ELAPSED_BITS-1:0] req_elapsed     = '0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic                    rsp_expired;

   // fixed outcome that travels with the word on the request port
   logic           word_typed   = 1'b0;
   timer_outcome_t word_outcome = '0;

   // private copy of the timer table
   logic                  live       [NUM_TIMERS];
   logic [KEY_BITS-1:0]   slot_key   [NUM_TIMERS];
   logic [COUNT_BITS-1:0] slot_count [NUM_TIMERS];
   logic [LIMIT_BITS-1:0] slot_limit [NUM_TIMERS];

   timer_outcome_t pending_outcomes [$];
   int unsigned    mismatches   = 0;
   int unsigned    words_sent   = 0;
   int unsigned    idle_pct     = 0;
   bit             hold_request = 1'b0;
   logic [15:0]    key_pool [KEY_POOL];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keyed_timer_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_timer_key   (req_timer_key),
      .req_limit_value (req_limit_value),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_expired     (rsp_expired)
   );

   // Apply one action word to the table copy and return the response it owes.
   function automatic timer_outcome_t apply_timer_action(
         input logic [ACTION_BITS-1:0]  act,
         input logic [15:0]             key_in,
         input logic [LIMIT_BITS-1:0]   lim,
         input logic [ELAPSED_BITS-1:0] el);
      timer_outcome_t        res;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS:0]   sum;
      int                    hit;
      int                    hole;
      int                    i;
      res.status  = STAT_DONE;
      res.expired = 1'b0;
      key  = key_in[KEY_BITS-1:0];
      hit  = -1;
      hole = -1;
      for (i = 0; i < NUM_TIMERS; i++) begin
         if (live[i] && slot_key[i] == key && hit < 0) hit = i;
         if (!live[i] && hole < 0) hole = i;
      end
      case (act)
         ACT_REGISTER: begin
            // a duplicate key wins over a full table
            if (hit >= 0) begin
               res.status = STAT_EXISTS;
            end else if (hole < 0) begin
               res.status = STAT_FULL;
            end else begin
               live[hole]       = 1'b1;
               slot_key[hole]   = key;
               slot_count[hole] = '0;
               slot_limit[hole] = lim;
            end
         end
         ACT_UNREGISTER: begin
            if (hit < 0) res.status = STAT_NOT_FOUND;
            else live[hit] = 1'b0;
         end
         ACT_TICK: begin
            // saturate every live count at its ceiling
            for (i = 0; i < NUM_TIMERS; i++) begin
               if (live[i]) begin
                  sum = {1'b0, slot_count[i]} + (COUNT_BITS + 1)'(el);
                  slot_count[i] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_BITS-1:0];
               end
            end
         end
         ACT_CHECK: begin
            if (hit < 0) res.status = STAT_NOT_FOUND;
            else res.expired = (slot_count[hit] >= slot_limit[hit]);
         end
         ACT_RESET_CNT: begin
            if (hit < 0) res.status = STAT_NOT_FOUND;
            else slot_count[hit] = '0;
         end
         ACT_SET_LIMIT: begin
            if (hit < 0) res.status = STAT_NOT_FOUND;
            else slot_limit[hit] = lim;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void flag_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endfunction

   // No gap unless the idle percentage draws one; then mostly a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] pick_key();
      if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic [LIMIT_BITS-1:0] pick_limit();
      logic [31:0] r;
      int unsigned pick;
      r    = $urandom();
      pick = $urandom_range(0, 9);
      if (pick < 6) return LIMIT_BITS'($urandom_range(0, 200000));
      if (pick == 6) return '0;
      return r[LIMIT_BITS-1:0];
   endfunction

   function automatic logic [ELAPSED_BITS-1:0] pick_elapsed();
      if ($urandom_range(0, 4) == 0) return ELAPSED_BITS'($urandom_range(0, 15));
      return ELAPSED_BITS'($urandom_range(0, 16'hFFFF));
   endfunction

   // Offer one word after a random gap and hold it until the block takes it.
   // Return right after the accepting edge.
   task automatic send_word(input logic [ACTION_BITS-1:0]  act,
                            input logic [15:0]             key,
                            input logic [LIMIT_BITS-1:0]   lim,
                            input logic [ELAPSED_BITS-1:0] el,
                            input logic                    typed   = 1'b0,
                            input timer_outcome_t          outcome = '0);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_timer_key   <= key;
      req_limit_value <= lim;
      req_elapsed     <= el;
      word_typed      <= typed;
      word_outcome    <= outcome;
      do @(posedge clock); while (req_ready !== 1'b1);
      words_sent++;
   endtask

   task automatic send_random_word();
      logic [ACTION_BITS-1:0] act;
      int unsigned            pick;
      pick = $urandom_range(0, 99);
      if      (pick < 25) act = ACT_REGISTER;
      else if (pick < 40) act = ACT_UNREGISTER;
      else if (pick < 58) act = ACT_TICK;
      else if (pick < 78) act = ACT_CHECK;
      else if (pick < 87) act = ACT_RESET_CNT;
      else if (pick < 96) act = ACT_SET_LIMIT;
      else if (pick < 98) act = ACT_SPARE6;
      else                act = ACT_SPARE7;
      send_word(act, pick_key(), pick_limit(), pick_elapsed());
   endtask

   // Walk one timer through its life: register, run, check, rearm and, at random, retire.
   task automatic run_timer_life();
      logic [15:0] key;
      int unsigned ticks;
      key   = key_pool[$urandom_range(0, KEY_POOL - 1)];
      ticks = $urandom_range(1, 4);
      send_word(ACT_REGISTER, key, LIMIT_BITS'($urandom_range(0, 150000)), pick_elapsed());
      repeat (ticks) send_word(ACT_TICK, pick_key(), pick_limit(), pick_elapsed());
      send_word(ACT_CHECK, key, pick_limit(), pick_elapsed());
      if ($urandom_range(0, 1) == 1) begin
         send_word(ACT_RESET_CNT, key, pick_limit(), pick_elapsed());
         send_word(ACT_CHECK, key, pick_limit(), pick_elapsed());
      end
      send_word(ACT_SET_LIMIT, key, pick_limit(), pick_elapsed());
      send_word(ACT_CHECK, key, pick_limit(), pick_elapsed());
      if ($urandom_range(0, 1) == 1)
         send_word(ACT_UNREGISTER, key, pick_limit(), pick_elapsed());
   endtask

   // Check the response word first, since it always belongs to an older
   // request, then predict the request word taken at the same edge.
   always @(posedge clock) begin : check_and_predict
      timer_outcome_t want;
      timer_outcome_t predicted;
      int             i;
      if (reset) begin
         for (i = 0; i < NUM_TIMERS; i++) live[i] = 1'b0;
         pending_outcomes.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("unrequested response", 32'd0, 32'({rsp_status, rsp_expired}));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("rsp_status", 32'(want.status), 32'(rsp_status));
               if (rsp_expired !== want.expired)
                  flag_mismatch("rsp_expired", 32'(want.expired), 32'(rsp_expired));
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            // run the table copy even when the outcome is fixed, to keep state
            predicted = apply_timer_action(req_action, req_timer_key, req_limit_value,
                                           req_elapsed);
            pending_outcomes.insert(pending_outcomes.size(),
                                    word_typed ? word_outcome : predicted);
         end
      end
   end

   // Response side: stall at random, or hold off for a long stretch on demand
   // so that the block backs up and drops req_ready.
   initial begin : response_side
      int unsigned stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = LONG_HOLD;
         end else if (stall == 0) begin
            stall = pick_gap();
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int          i;
      int unsigned random_start;
      int unsigned next_shift;
      bit          held;
      held     = 1'b0;
      idle_pct = 30;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(DIRECTED_ROWS); i++)
         send_word(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].limit,
                   DIRECTED_ROWS[i].elapsed, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].outcome);

      // Fill the table beside the live 16'hFFFF timer, then probe the full case
      // and a duplicate that must win over it.
      for (i = 0; i < NUM_TIMERS - 1; i++)
         send_word(ACT_REGISTER, 16'(FILL_BASE + i), LIMIT_BITS'($urandom_range(0, 1000)),
                   '0);
      send_word(ACT_REGISTER, 16'hABCD, '0, '0, 1'b1, '{STAT_FULL, 1'b0});
      send_word(ACT_REGISTER, 16'hFFFF, '0, '0, 1'b1, '{STAT_EXISTS, 1'b0});

      // Advance every count of the full table at once; a few large ticks stay
      // far below the top limit.
      send_word(ACT_SET_LIMIT, 16'hFFFF, LIMIT_TOP, '0);
      repeat (FULL_TICKS)
         send_word(ACT_TICK, 16'($urandom_range(0, 16'hFFFF)), '0, ELAPSED_TOP);
      send_word(ACT_CHECK, 16'hFFFF, '0, '0, 1'b1, '{STAT_DONE, 1'b0});
      send_word(ACT_CHECK, FILL_BASE[15:0], '0, '0);
      send_word(ACT_RESET_CNT, 16'hFFFF, '0, '0);
      send_word(ACT_CHECK, 16'hFFFF, '0, '0, 1'b1, '{STAT_DONE, 1'b0});

      // Empty the table again before the random part.
      for (i = 0; i < NUM_TIMERS - 1; i++)
         send_word(ACT_UNREGISTER, 16'(FILL_BASE + i), '0, '0);
      send_word(ACT_UNREGISTER, 16'hFFFF, '0, '0);

      // A small key pool keeps hits, misses, duplicates and a full table common.
      for (i = 0; i < KEY_POOL; i++) key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
      key_pool[0] = '0;
      key_pool[1] = '1;

      random_start = words_sent;
      next_shift   = words_sent;
      while (words_sent < random_start + RANDOM_WORDS) begin
         // change the idling mix every few dozen words, calm stretches included
         if (words_sent >= next_shift) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
            next_shift += 50;
         end
         if (!held && words_sent >= random_start + 500) begin
            hold_request = 1'b1;
            held         = 1'b1;
         end
         if ($urandom_range(0, 9) < 3) run_timer_life();
         else send_random_word();
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then watch a while longer for stray responses
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #6000000;
      $display("status: fail");
      $finish;
   end

endmodule
